// File: hdl/ldf_pkg.sv
`timescale 1ns / 1ps

package ldf_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME_LEN = 2'd1;

  // Register widths and reset values
  localparam int HB_W  = 4;
  localparam int LEN_W = 31;
  localparam logic [HB_W-1:0]  HB_RESET      = 4'd4;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 31'd65536;

  // Supported header widths
  localparam logic [HB_W-1:0] HB_ONE   = 4'd1;
  localparam logic [HB_W-1:0] HB_TWO   = 4'd2;
  localparam logic [HB_W-1:0] HB_FOUR  = 4'd4;
  localparam logic [HB_W-1:0] HB_EIGHT = 4'd8;

  // Command queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = 3;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_ERROR,
    CMD_REPLAY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t       kind;
    logic [7:0]      data;
    logic            last;
    logic [HB_W-1:0] count;
  } cmd_t;

  function automatic logic width_ok(input logic [HB_W-1:0] hb);
    return (hb == HB_ONE) || (hb == HB_TWO) || (hb == HB_FOUR) || (hb == HB_EIGHT);
  endfunction

endpackage

// File: hdl/ldf_if.sv
`timescale 1ns / 1ps

interface ldf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ldf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic       length_error;

  modport source (output valid, output out_byte, output frame_first, output frame_last,
                  output length_error, input ready);
  modport sink   (input valid, input out_byte, input frame_first, input frame_last,
                  input length_error, output ready);
endinterface

interface ldf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ldf_pkg::CFG_IDX_W-1:0]  index;
  logic [ldf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hdl/length_prefix_deframer.sv
`timescale 1ns / 1ps
// Path from the transfer of a payload byte, or of the final header byte, to its first result
//   on tx: front classify into queue, back command register, output register.
// Throughput: one input byte per cycle while the queue has room, and one result per cycle
//   while tx is ready; a header replay of N bytes gives N results, overlapped with the next input.
// Reset (rst, synchronous): clears parser counts, the command queue and tx.valid;
//   header_bytes returns to 4 and max_frame_len to 65536.
module length_prefix_deframer #(
  parameter int MAX_HEADER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  ldf_byte_if.sink    rx,
  ldf_frame_if.source tx,
  ldf_cfg_if.sink     cfg
);

  localparam int HDR_W = 8 * MAX_HEADER_BYTES;
  localparam int Q_W   = $bits(ldf_pkg::cmd_t) + HDR_W;

  logic [ldf_pkg::HB_W-1:0]  header_bytes;
  logic [ldf_pkg::LEN_W-1:0] max_frame_len;

  logic             f_push, q_ready, q_valid, q_pop;
  ldf_pkg::cmd_t    f_cmd, q_cmd;
  logic [HDR_W-1:0] f_hdr, q_hdr;
  logic [Q_W-1:0]   q_out;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_bytes  <= ldf_pkg::HB_RESET;
      max_frame_len <= ldf_pkg::MAX_LEN_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == ldf_pkg::REG_HEADER_BYTES) begin
        header_bytes <= cfg.data[ldf_pkg::HB_W-1:0];
      end else if (cfg.index == ldf_pkg::REG_MAX_FRAME_LEN) begin
        max_frame_len <= cfg.data[ldf_pkg::LEN_W-1:0];
      end
    end
  end

  ldf_front #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .rx           (rx),
    .header_bytes (header_bytes),
    .max_frame_len(max_frame_len),
    .q_ready      (q_ready),
    .push         (f_push),
    .cmd          (f_cmd),
    .hdr          (f_hdr)
  );

  ldf_queue #(
    .WIDTH(Q_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_push),
    .push_data ({f_cmd, f_hdr}),
    .push_ready(q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out)
  );

  assign q_cmd = q_out[Q_W-1 -: $bits(ldf_pkg::cmd_t)];
  assign q_hdr = q_out[HDR_W-1:0];

  ldf_back #(
    .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_valid(q_valid),
    .q_cmd  (q_cmd),
    .q_hdr  (q_hdr),
    .q_pop  (q_pop),
    .tx     (tx)
  );

  // Error results carry no byte and no frame marks
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    tx.valid && tx.length_error |-> tx.out_byte == 8'd0 && !tx.frame_first && !tx.frame_last)
    else $error("error result with nonzero fields");

  // Nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !tx.valid)
    else $error("result offered right after reset");

  // The front never queues a command the queue cannot take
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    f_push |-> q_ready)
    else $error("command pushed into full queue");

  // A command is only popped from a non-empty queue, while the back is idle or emits its last result
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("pop from empty queue");

endmodule

// File: hdl/ldf_front.sv
`timescale 1ns / 1ps

module ldf_front #(
  parameter int MAX_HEADER_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  ldf_byte_if.sink                      rx,
  input  logic [ldf_pkg::HB_W-1:0]      header_bytes,
  input  logic [ldf_pkg::LEN_W-1:0]     max_frame_len,
  input  logic                          q_ready,
  output logic                          push,
  output ldf_pkg::cmd_t                 cmd,
  output logic [8*MAX_HEADER_BYTES-1:0] hdr
);

  localparam int HDR_W = 8 * MAX_HEADER_BYTES;
  localparam int CNT_W = $clog2(MAX_HEADER_BYTES + 1);

  logic [CNT_W-1:0]          header_count, header_count_next;
  logic [ldf_pkg::LEN_W-1:0] bytes_remaining, bytes_remaining_next;
  logic [HDR_W-1:0]          acc, acc_next, acc_merged;
  logic [ldf_pkg::HB_W-1:0]  hc_ext;
  logic [63:0]               len64;
  logic                      accept, head_bad, complete, len_bad;

  assign rx.ready = q_ready;
  assign accept   = rx.valid && rx.ready;

  // Drop the incoming byte into its header slot
  always_comb begin
    for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
      acc_merged[8*i +: 8] = (header_count == CNT_W'(i)) ? rx.data_byte : acc[8*i +: 8];
    end
  end

  // Classify the header byte
  assign hc_ext   = ldf_pkg::HB_W'(header_count);
  assign head_bad = !ldf_pkg::width_ok(header_bytes)
                    || (header_bytes > ldf_pkg::HB_W'(MAX_HEADER_BYTES))
                    || (hc_ext >= header_bytes)
                    || (header_count >= CNT_W'(MAX_HEADER_BYTES));
  assign complete = (hc_ext + 4'd1) == header_bytes;
  assign len64    = 64'(acc_merged);
  assign len_bad  = rx.data_byte[7] || (len64 == 64'd0)
                    || (len64 > 64'(max_frame_len)) || (len64 < 64'(header_bytes));

  // Next parser state and the command to queue
  always_comb begin
    header_count_next    = header_count;
    bytes_remaining_next = bytes_remaining;
    acc_next             = acc;
    push                 = 1'b0;
    cmd.kind             = ldf_pkg::CMD_PASS;
    cmd.data             = rx.data_byte;
    cmd.last             = 1'b0;
    cmd.count            = header_bytes;
    hdr                  = acc_merged;
    if (bytes_remaining != '0) begin
      push                 = accept;
      cmd.last             = (bytes_remaining == 31'd1);
      bytes_remaining_next = bytes_remaining - 31'd1;
    end else if (head_bad) begin
      push                 = accept;
      cmd.kind             = ldf_pkg::CMD_ERROR;
      header_count_next    = '0;
      acc_next             = '0;
    end else if (complete) begin
      push                 = accept;
      header_count_next    = '0;
      acc_next             = '0;
      if (len_bad) begin
        cmd.kind = ldf_pkg::CMD_ERROR;
      end else begin
        cmd.kind             = ldf_pkg::CMD_REPLAY;
        cmd.last             = (len64 == 64'(header_bytes));
        bytes_remaining_next = len64[ldf_pkg::LEN_W-1:0] - ldf_pkg::LEN_W'(header_bytes);
      end
    end else begin
      header_count_next = header_count + CNT_W'(1);
      acc_next          = acc_merged;
    end
  end

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      header_count    <= '0;
      bytes_remaining <= '0;
      acc             <= '0;
    end else if (accept) begin
      header_count    <= header_count_next;
      bytes_remaining <= bytes_remaining_next;
      acc             <= acc_next;
    end
  end

endmodule

// File: hdl/ldf_queue.sv
`timescale 1ns / 1ps

module ldf_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ready,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]          mem [ldf_pkg::QDEPTH];
  logic [ldf_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [ldf_pkg::QPTR_W:0]   count;
  logic                      do_push, do_pop;

  assign push_ready = count != (ldf_pkg::QPTR_W + 1)'(ldf_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/ldf_back.sv
`timescale 1ns / 1ps

module ldf_back #(
  parameter int MAX_HEADER_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  ldf_pkg::cmd_t                 q_cmd,
  input  logic [8*MAX_HEADER_BYTES-1:0] q_hdr,
  output logic                          q_pop,
  ldf_frame_if.source                   tx
);

  localparam int HDR_W = 8 * MAX_HEADER_BYTES;
  localparam int IDX_W = (MAX_HEADER_BYTES > 1) ? $clog2(MAX_HEADER_BYTES) : 1;

  ldf_pkg::cmd_t    cur;
  logic [HDR_W-1:0] cur_hdr;
  logic [IDX_W-1:0] idx;
  logic             busy;

  logic       load, emit, final_out;
  logic [7:0] sel_byte, o_byte;
  logic       o_first, o_last, o_err;

  assign load  = !tx.valid || tx.ready;
  assign emit  = busy && load;
  assign q_pop = q_valid && (!busy || (emit && final_out));

  // Pick the replayed header byte
  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < MAX_HEADER_BYTES; i++) begin
      if (idx == IDX_W'(i)) begin
        sel_byte = cur_hdr[8*i +: 8];
      end
    end
  end

  // Form the next result from the current command
  always_comb begin
    final_out = 1'b1;
    o_byte    = '0;
    o_first   = 1'b0;
    o_last    = 1'b0;
    o_err     = 1'b0;
    unique case (cur.kind)
      ldf_pkg::CMD_PASS: begin
        o_byte = cur.data;
        o_last = cur.last;
      end
      ldf_pkg::CMD_ERROR: begin
        o_err = 1'b1;
      end
      ldf_pkg::CMD_REPLAY: begin
        final_out = (ldf_pkg::HB_W'(idx) + 4'd1) == cur.count;
        o_byte    = sel_byte;
        o_first   = (idx == '0);
        o_last    = final_out && cur.last;
      end
      default: begin
        o_err = 1'b0;
      end
    endcase
  end

  // Hold the current command and step through its results
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (emit && final_out) begin
      busy <= 1'b0;
    end else if (emit) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_cmd;
      cur_hdr <= q_hdr;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      tx.valid <= 1'b0;
    end else if (load) begin
      tx.valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      tx.out_byte     <= o_byte;
      tx.frame_first  <= o_first;
      tx.frame_last   <= o_last;
      tx.length_error <= o_err;
    end
  end

endmodule

// File: tb/tb_length_prefix_deframer.sv
`timescale 1ns / 1ps

module tb_length_prefix_deframer;

  localparam int PIPE_LATENCY  = 3;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 3;
  localparam int CYCLE_LIMIT   = 200000;
  localparam logic [ldf_pkg::HB_W-1:0] MAX_HDR = 4'd8;

  // Indexes past the end of the register list; writes to them must be ignored
  localparam logic [ldf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [ldf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       err;
  } frame_beat_t;

  logic clk;
  logic rst;

  ldf_byte_if  rx();
  ldf_frame_if tx();
  ldf_cfg_if   cfg();

  length_prefix_deframer DUT (
    .clk (clk),
    .rst (rst),
    .rx  (rx),
    .tx  (tx),
    .cfg (cfg)
  );

  // Expected output beats, oldest first
  frame_beat_t expected_beats[$];

  // Deframer state as predicted from the accepted bytes
  logic [ldf_pkg::HB_W-1:0]  pred_hdr_width;
  logic [ldf_pkg::LEN_W-1:0] pred_max_len;
  logic [ldf_pkg::HB_W-1:0]  pred_hdr_count;
  logic [7:0]                pred_hdr_store [8];
  logic [ldf_pkg::LEN_W-1:0] pred_remaining;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int bytes_sent     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("tb_length_prefix_deframer: FAIL");
      $finish;
    end
  end

  // Drive tx.ready: long hold-off when requested, else random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      tx.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      tx.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Compare each output transfer with the oldest expected beat
  always @(posedge clk) begin : check_results
    frame_beat_t want;
    if (!rst && tx.valid && tx.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual byte=%h first=%b last=%b err=%b",
                 $time, tx.out_byte, tx.frame_first, tx.frame_last, tx.length_error);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (tx.out_byte !== want.data || tx.frame_first !== want.first ||
            tx.frame_last !== want.last || tx.length_error !== want.err) begin
          $display({"%0t: mismatch: expected byte=%h first=%b last=%b err=%b, ",
                    "actual byte=%h first=%b last=%b err=%b"},
                   $time, want.data, want.first, want.last, want.err,
                   tx.out_byte, tx.frame_first, tx.frame_last, tx.length_error);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [7:0] rand_byte();
    logic [31:0] r;
    r = $urandom;
    return r[7:0];
  endfunction

  function automatic void expect_beat(input logic [7:0] data, input logic first,
                                      input logic last, input logic err);
    frame_beat_t beat;
    beat.data  = data;
    beat.first = first;
    beat.last  = last;
    beat.err   = err;
    expected_beats.push_back(beat);
  endfunction

  // Drop the frame in progress and expect one error beat
  function automatic void abort_frame();
    pred_hdr_count = '0;
    pred_remaining = '0;
    expect_beat(8'h00, 1'b0, 1'b0, 1'b1);
  endfunction

  // Advance the deframer state by one accepted byte
  function automatic void predict_byte(input logic [7:0] value);
    logic [63:0] frame_len;
    logic [63:0] payload_len;
    logic        width_legal;
    int          hdr_len;
    int          i;
    frame_len   = '0;
    hdr_len     = int'(pred_hdr_width);
    width_legal = (pred_hdr_width == ldf_pkg::HB_ONE) ||
                  (pred_hdr_width == ldf_pkg::HB_TWO) ||
                  (pred_hdr_width == ldf_pkg::HB_FOUR) ||
                  (pred_hdr_width == ldf_pkg::HB_EIGHT);
    // Pass payload through, mark the final byte
    if (pred_remaining != '0) begin
      pred_remaining = pred_remaining - 1'b1;
      expect_beat(value, 1'b0, pred_remaining == '0, 1'b0);
      return;
    end
    if (!width_legal || pred_hdr_count >= pred_hdr_width || pred_hdr_count >= MAX_HDR) begin
      abort_frame();
      return;
    end
    // Hold header bytes until the length is complete
    pred_hdr_store[pred_hdr_count[2:0]] = value;
    pred_hdr_count = pred_hdr_count + 1'b1;
    if (pred_hdr_count < pred_hdr_width) return;
    for (i = 0; i < hdr_len; i++) frame_len[8*i +: 8] = pred_hdr_store[i];
    if (pred_hdr_store[hdr_len-1][7] || frame_len == '0 ||
        frame_len > {33'd0, pred_max_len} || frame_len < {60'd0, pred_hdr_width}) begin
      abort_frame();
      return;
    end
    // Replay the header with the first mark
    for (i = 0; i < hdr_len; i++)
      expect_beat(pred_hdr_store[i], i == 0,
                  (i == hdr_len - 1) && (frame_len == {60'd0, pred_hdr_width}), 1'b0);
    pred_hdr_count = '0;
    payload_len    = frame_len - {60'd0, pred_hdr_width};
    pred_remaining = payload_len[ldf_pkg::LEN_W-1:0];
  endfunction

  // Offer one byte, with a random idle gap first
  task automatic send_byte(input logic [7:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      rx.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    rx.valid     <= 1'b1;
    rx.data_byte <= value;
    do @(posedge clk); while (!rx.ready);
    bytes_sent++;
    predict_byte(value);
  endtask

  // Hold the input until every expected beat has arrived and the pipe is empty
  task automatic drain_results();
    rx.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ldf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ldf_pkg::CFG_DATA_W-1:0] value,
                           input bit last_write);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    if (last_write) cfg.valid <= 1'b0;
    if (idx == ldf_pkg::REG_HEADER_BYTES) pred_hdr_width = value[ldf_pkg::HB_W-1:0];
    else if (idx == ldf_pkg::REG_MAX_FRAME_LEN) pred_max_len = value[ldf_pkg::LEN_W-1:0];
  endtask

  // Register words carry random bits above the field
  function automatic logic [ldf_pkg::CFG_DATA_W-1:0] width_word(
      input logic [ldf_pkg::HB_W-1:0] width);
    logic [ldf_pkg::CFG_DATA_W-1:0] w;
    w = $urandom;
    w[ldf_pkg::HB_W-1:0] = width;
    return w;
  endfunction

  task automatic set_regs(input logic [ldf_pkg::HB_W-1:0] width,
                          input logic [ldf_pkg::LEN_W-1:0] max_len);
    logic [ldf_pkg::CFG_DATA_W-1:0] len_word;
    len_word = $urandom;
    len_word[ldf_pkg::LEN_W-1:0] = max_len;
    write_reg(ldf_pkg::REG_HEADER_BYTES, width_word(width), 1'b0);
    write_reg(ldf_pkg::REG_MAX_FRAME_LEN, len_word, 1'b1);
  endtask

  // Send one frame under the current width: mostly legal, some bad lengths
  task automatic send_random_frame();
    logic [63:0] len_field;
    int          hdr_len;
    int          upper;
    int          pick;
    int          i;
    hdr_len = int'(pred_hdr_width);
    pick    = $urandom_range(99);
    if (pick < 75) begin
      upper     = (int'(pred_max_len) < hdr_len + 6) ? int'(pred_max_len) : hdr_len + 6;
      len_field = $urandom_range(hdr_len, upper);
    end else if (pick < 80) begin
      len_field = '0;
    end else if (pick < 86) begin
      len_field = {$urandom, $urandom};
      len_field[8*hdr_len-1] = 1'b1;
    end else if (pick < 93) begin
      len_field = {33'd0, pred_max_len} + 64'd1 + $urandom_range(0, 50);
    end else begin
      len_field = (hdr_len > 1) ? $urandom_range(1, hdr_len - 1) : 0;
    end
    for (i = 0; i < hdr_len; i++) send_byte(len_field[8*i +: 8]);
    while (pred_remaining != '0) send_byte(rand_byte());
  endtask

  // Inject junk, then feed bytes until the parser is back at a frame boundary
  task automatic send_noise();
    repeat ($urandom_range(1, 3)) send_byte(rand_byte());
    while (pred_hdr_count != '0 || pred_remaining != '0) send_byte(rand_byte());
  endtask

  task automatic run_traffic(input int idle_pct, input int stall_pct,
                             input logic [ldf_pkg::HB_W-1:0] width, input int n_bytes);
    logic [31:0] limit;
    int          start;
    drain_results();
    limit = $urandom_range(4, 24) + width;
    set_regs(width, limit[ldf_pkg::LEN_W-1:0]);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      if ($urandom_range(99) < 10) send_noise();
      else send_random_frame();
    end
    drain_results();
  endtask

  // Default registers: 4-byte header, frame of five bytes
  task automatic test_reset_defaults();
    send_byte(8'h05);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    drain_results();
  endtask

  // One-byte header with the smallest limit: one-byte frame, too long, zero, negative
  task automatic test_one_byte_header_limits();
    set_regs(ldf_pkg::HB_ONE, 31'd1);
    send_byte(8'h01);
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h80);
    drain_results();
  endtask

  // Width change inside a payload takes effect at the next header
  task automatic test_register_change_in_payload();
    set_regs(ldf_pkg::HB_ONE, 31'd10);
    send_byte(8'h03);
    send_byte(8'hA5);
    drain_results();
    write_reg(ldf_pkg::REG_HEADER_BYTES, width_word(ldf_pkg::HB_TWO), 1'b1);
    send_byte(8'h5A);
    // header-only frame, then a length shorter than its header
    send_byte(8'h02);
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h00);
    drain_results();
  endtask

  // 8-byte header with the largest limit: 2^31 is positive but too long
  task automatic test_eight_byte_header_extreme();
    int i;
    set_regs(ldf_pkg::HB_EIGHT, 31'h7FFF_FFFF);
    for (i = 0; i < 8; i++) send_byte((i == 3) ? 8'h80 : 8'h00);
    drain_results();
  endtask

  task automatic test_unsupported_width();
    logic [31:0] w;
    w = $urandom_range(5, 7);
    if (w == 32'd6) w = 32'd3;
    set_regs(w[ldf_pkg::HB_W-1:0], 31'd64);
    send_byte(rand_byte());
    drain_results();
  endtask

  // Shrink the width below the bytes already held
  task automatic test_width_change_mid_header();
    set_regs(ldf_pkg::HB_FOUR, 31'd64);
    send_byte(8'h10);
    send_byte(8'h00);
    send_byte(8'h00);
    drain_results();
    write_reg(ldf_pkg::REG_HEADER_BYTES, width_word(ldf_pkg::HB_TWO), 1'b1);
    send_byte(8'h33);
    drain_results();
  endtask

  // Writes past the register list leave the 2-byte setting in place
  task automatic test_spare_register_index();
    write_reg(REG_SPARE_A, $urandom, 1'b0);
    write_reg(REG_SPARE_B, $urandom, 1'b1);
    send_byte(8'h03);
    send_byte(8'h00);
    send_byte(8'hAB);
    drain_results();
  endtask

  task automatic test_random_traffic();
    run_traffic(0, 0, ldf_pkg::HB_ONE, 20);
    run_traffic(73, 0, ldf_pkg::HB_TWO, 20);
    run_traffic(0, 73, ldf_pkg::HB_FOUR, 20);
    run_traffic(34, 34, ldf_pkg::HB_EIGHT, 20);
  endtask

  // Hold off the receiver while the sender keeps offering, so the input stalls
  task automatic test_output_backpressure();
    int start;
    drain_results();
    set_regs(ldf_pkg::HB_TWO, 31'd12);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 300;
    start = bytes_sent;
    while (bytes_sent - start < 30) send_random_frame();
    drain_results();
  endtask

  initial begin
    rst          <= 1'b1;
    rx.valid     <= 1'b0;
    rx.data_byte <= 8'h00;
    cfg.valid    <= 1'b0;
    cfg.index    <= ldf_pkg::REG_HEADER_BYTES;
    cfg.data     <= '0;
    pred_hdr_width = ldf_pkg::HB_RESET;
    pred_max_len   = ldf_pkg::MAX_LEN_RESET;
    pred_hdr_count = '0;
    pred_remaining = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_one_byte_header_limits();
    test_register_change_in_payload();
    test_eight_byte_header_extreme();
    test_unsupported_width();
    test_width_change_mid_header();
    test_spare_register_index();
    test_random_traffic();
    test_output_backpressure();

    drain_results();
    repeat (4 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("tb_length_prefix_deframer: PASS");
    end else begin
      $display("tb_length_prefix_deframer: FAIL");
    end
    $finish;
  end

endmodule
